FILE: rtl/lmfcg_pkg.sv
// Shared constants, types and helpers for the LED matrix frame command generator.
`timescale 1ns / 1ps

package lmfcg_pkg;

  localparam int unsigned COLUMNS     = 6;
  localparam int unsigned PAD_BYTES   = 4;
  localparam int unsigned FRAME_BYTES = 2 * COLUMNS;
  localparam int unsigned XFER_BYTES  = 2 + FRAME_BYTES + PAD_BYTES;
  localparam int unsigned FRAME_AW    = $clog2(FRAME_BYTES);
  localparam int unsigned IDX_W       = $clog2(XFER_BYTES);

  localparam logic [7:0] CMD_DISPLAY_OFF = 8'h80;
  localparam logic [7:0] CMD_DISPLAY_ON  = 8'h81;
  localparam logic [7:0] CMD_DIM_BASE    = 8'hE0;
  localparam logic [7:0] CMD_SLEEP       = 8'h20;
  localparam logic [7:0] CMD_WAKE        = 8'h21;

  localparam logic [7:0] DEV_ADDR_RESET  = 8'hE0;
  localparam logic [7:0] RAM_PTR_RESET   = 8'h00;
  localparam logic [4:0] BREATH_RESET    = 5'd8;
  localparam logic [4:0] BREATH_TOP      = 5'd16;
  localparam logic [4:0] LEVEL_MAX       = 5'd15;

  typedef enum logic [2:0] {
    REQ_DRAW    = 3'd0,
    REQ_FILL    = 3'd1,
    REQ_REFRESH = 3'd2,
    REQ_DISPLAY = 3'd3,
    REQ_BRIGHT  = 3'd4,
    REQ_BREATH  = 3'd5,
    REQ_SLEEP   = 3'd6,
    REQ_WAKE    = 3'd7
  } req_e;

  typedef enum logic [0:0] {
    CFG_DEV_ADDR = 1'b0,
    CFG_RAM_PTR  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [2:0] col;
    logic [3:0] row;
    logic       value;
    logic [1:0] blink;
    logic [4:0] level;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       first_of_transfer;
    logic       last_of_transfer;
  } out_item_t;

  typedef struct packed {
    logic                we;
    logic [FRAME_AW-1:0] waddr;
    logic [7:0]          wdata;
    logic                re;
    logic [FRAME_AW-1:0] raddr;
  } ram_req_t;

  function automatic logic [7:0] dim_byte(input logic [4:0] lvl);
    logic [3:0] l;
    if (lvl > LEVEL_MAX) begin
      l = LEVEL_MAX[3:0];
    end else if (lvl == 5'd0) begin
      l = 4'd1;
    end else begin
      l = lvl[3:0];
    end
    return CMD_DIM_BASE | {4'd0, l - 4'd1};
  endfunction

endpackage

FILE: rtl/lmfcg_frame_ram.sv
// Frame buffer RAM: one write port, one registered read port, per-entry valid bits.
`timescale 1ns / 1ps

module lmfcg_frame_ram
  import lmfcg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ram_req_t   req_i,
  output logic [7:0] rdata_o
);

  logic [7:0]             mem [FRAME_BYTES];
  logic [FRAME_BYTES-1:0] valid_q;
  logic [7:0]             rdata_q;
  logic                   rvalid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  // unwritten entries read as the cleared frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvalid_q <= valid_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : 8'h00;

endmodule

FILE: rtl/led_matrix_frame_command_generator_unit.sv
// LED matrix frame command generator: frame RAM sequencer emitting two-wire bus bytes.
`timescale 1ns / 1ps

// Takes one request at a time and turns it into bus write bytes, with the first
// byte of each transfer flagged for a start and the last for a stop. A refresh
// streams 2 + 2*COLUMNS + PAD_BYTES bytes (18 by default), one per cycle while the
// output is not stalled, fed by the single read port of the frame RAM with one byte
// of prefetch; the next request is taken the cycle after its last byte enters the
// output register. Display, brightness, sleep, wake and an emitting breath tick
// send two bytes. A dot draw is a read-modify-write of one RAM entry, a fill
// writes one entry per cycle, and a breath tick that only turns the ramp around
// sends no bytes. The frame reads as cleared right after reset; no clearing pass
// is needed. Configuration writes take effect at once and belong in idle periods.
module led_matrix_frame_command_generator_unit
  import lmfcg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DRAW = 2'd1;
  localparam logic [1:0] ST_FILL = 2'd2;
  localparam logic [1:0] ST_SEND = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [FRAME_AW-1:0] fill_q, fill_d;
  logic                refresh_q, refresh_d;
  logic [7:0]          cmd_q, cmd_d;
  logic [FRAME_AW-1:0] dot_addr_q, dot_addr_d;
  logic [7:0]          dot_mask_q, dot_mask_d;
  logic                dot_val_q, dot_val_d;
  logic [4:0]          breath_lvl_q, breath_lvl_d;
  logic                breath_rise_q, breath_rise_d;
  logic [7:0]          dev_addr_q, ram_ptr_q;
  logic                out_valid_q;
  out_item_t           out_q;

  logic                accept, slot_free, load, send_last, col_ok, br_emit;
  logic [IDX_W-1:0]    last_idx, idx_m1;
  logic [3:0]          dot_sum;
  logic [7:0]          tx_byte, rdata;
  ram_req_t            ram_req;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign load       = (state_q == ST_SEND) && slot_free;
  assign last_idx   = refresh_q ? IDX_W'(XFER_BYTES - 1) : IDX_W'(1);
  assign send_last  = (idx_q == last_idx);
  assign idx_m1     = idx_q - IDX_W'(1);
  assign dot_sum    = {in_data_i.col, in_data_i.row[3]};
  assign col_ok     = ({1'b0, in_data_i.col} < 4'(COLUMNS));
  assign br_emit    = breath_rise_q ? (breath_lvl_q <= BREATH_TOP) : (breath_lvl_q != 5'd0);

  lmfcg_frame_ram u_frame_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  always_comb begin
    if (idx_q == '0) begin
      tx_byte = dev_addr_q;
    end else if (!refresh_q) begin
      tx_byte = cmd_q;
    end else if (idx_q == IDX_W'(1)) begin
      tx_byte = ram_ptr_q;
    end else if (idx_q <= IDX_W'(FRAME_BYTES + 1)) begin
      tx_byte = rdata;
    end else begin
      tx_byte = 8'h00;
    end
  end

  always_comb begin
    ram_req = '0;
    if (accept && (in_data_i.req_type == REQ_DRAW) && col_ok) begin
      ram_req.re    = 1'b1;
      ram_req.raddr = dot_sum[FRAME_AW-1:0];
    end
    // prefetch the frame byte sent after this one
    if (load && refresh_q && (idx_q != '0) && (idx_q <= IDX_W'(FRAME_BYTES))) begin
      ram_req.re    = 1'b1;
      ram_req.raddr = idx_m1[FRAME_AW-1:0];
    end
    if (state_q == ST_DRAW) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = dot_addr_q;
      ram_req.wdata = dot_val_q ? (rdata | dot_mask_q) : (rdata & ~dot_mask_q);
    end
    if (state_q == ST_FILL) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = fill_q;
      ram_req.wdata = {8{dot_val_q}};
    end
  end

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    fill_d        = fill_q;
    refresh_d     = refresh_q;
    cmd_d         = cmd_q;
    dot_addr_d    = dot_addr_q;
    dot_mask_d    = dot_mask_q;
    dot_val_d     = dot_val_q;
    breath_lvl_d  = breath_lvl_q;
    breath_rise_d = breath_rise_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d     = '0;
          refresh_d = 1'b0;
          case (in_data_i.req_type)
            REQ_DRAW: begin
              dot_addr_d = dot_sum[FRAME_AW-1:0];
              dot_mask_d = 8'd1 << in_data_i.row[2:0];
              dot_val_d  = in_data_i.value;
              if (col_ok) begin
                state_d = ST_DRAW;
              end
            end
            REQ_FILL: begin
              dot_val_d = in_data_i.value;
              fill_d    = '0;
              state_d   = ST_FILL;
            end
            REQ_REFRESH: begin
              refresh_d = 1'b1;
              state_d   = ST_SEND;
            end
            REQ_DISPLAY: begin
              cmd_d   = in_data_i.value ? (CMD_DISPLAY_ON | {5'd0, in_data_i.blink, 1'b0})
                                        : CMD_DISPLAY_OFF;
              state_d = ST_SEND;
            end
            REQ_BRIGHT: begin
              cmd_d   = dim_byte(in_data_i.level);
              state_d = ST_SEND;
            end
            REQ_BREATH: begin
              cmd_d = dim_byte(breath_lvl_q);
              if (br_emit) begin
                breath_lvl_d = breath_rise_q ? breath_lvl_q + 5'd1 : breath_lvl_q - 5'd1;
                state_d      = ST_SEND;
              end else begin
                breath_lvl_d  = breath_rise_q ? BREATH_TOP : 5'd1;
                breath_rise_d = !breath_rise_q;
              end
            end
            REQ_SLEEP: begin
              cmd_d   = CMD_SLEEP;
              state_d = ST_SEND;
            end
            default: begin
              cmd_d   = CMD_WAKE;
              state_d = ST_SEND;
            end
          endcase
        end
      end
      ST_DRAW: begin
        state_d = ST_IDLE;
      end
      ST_FILL: begin
        fill_d = fill_q + FRAME_AW'(1);
        if (fill_q == FRAME_AW'(FRAME_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_SEND: begin
        if (load) begin
          idx_d = idx_q + IDX_W'(1);
          if (send_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      breath_lvl_q  <= BREATH_RESET;
      breath_rise_q <= 1'b0;
      dev_addr_q    <= DEV_ADDR_RESET;
      ram_ptr_q     <= RAM_PTR_RESET;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      breath_lvl_q  <= breath_lvl_d;
      breath_rise_q <= breath_rise_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DEV_ADDR: dev_addr_q <= cfg_data_i;
          CFG_RAM_PTR:  ram_ptr_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    fill_q     <= fill_d;
    refresh_q  <= refresh_d;
    cmd_q      <= cmd_d;
    dot_addr_q <= dot_addr_d;
    dot_mask_q <= dot_mask_d;
    dot_val_q  <= dot_val_d;
    if (load) begin
      out_q.tx_byte           <= tx_byte;
      out_q.first_of_transfer <= (idx_q == '0);
      out_q.last_of_transfer  <= send_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_ram_single_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req.we && ram_req.re))
    else $error("frame RAM read and write in the same cycle");

  a_breath_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    breath_lvl_q <= BREATH_TOP + 5'd1)
    else $error("breath level out of range");

  a_send_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && send_last |=> (state_q == ST_IDLE) && out_valid_o && out_data_o.last_of_transfer)
    else $error("transfer did not end with a stop byte");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> (fill_q <= FRAME_AW'(FRAME_BYTES - 1)))
    else $error("fill address past frame end");

endmodule

FILE: tb/led_matrix_frame_command_generator_unit_test.sv
// Self-checking testbench for the LED matrix frame command generator: predicted vs. emitted bus bytes.
`timescale 1ns / 1ps

module led_matrix_frame_command_generator_unit_test;
  import lmfcg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = XFER_BYTES + 8;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  in_item_t   in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_item_t  out_data_o;
  logic       cfg_we_i = 1'b0;
  logic       cfg_idx_i = 1'b0;
  logic [7:0] cfg_data_i = 8'h00;

  led_matrix_frame_command_generator_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Mirror of the block state
  logic [7:0] frame_img [FRAME_BYTES];
  logic [4:0] breath_lvl = BREATH_RESET;
  logic       breath_up = 1'b0;
  logic [7:0] dev_addr = DEV_ADDR_RESET;
  logic [7:0] ram_ptr = RAM_PTR_RESET;

  in_item_t    pending_reqs[$];
  out_item_t   bus_bytes_due[$];
  int unsigned queued_items = 0;
  int unsigned err_count = 0;
  int unsigned bytes_checked = 0;
  int unsigned reg_settings = 1;
  int unsigned items_taken [8];
  int unsigned cycles = 0;

  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned stall_phase = 0;

  initial begin
    foreach (frame_img[i]) frame_img[i] = 8'h00;
    foreach (items_taken[i]) items_taken[i] = 0;
  end

  task automatic flag_error(input string what);
    $display("ERROR at %0t: %s", $time, what);
    err_count++;
  endtask

  function automatic logic [7:0] brightness_code(input logic [4:0] lv);
    logic [7:0] step;
    if (lv == 5'd0) step = 8'd0;
    else if (lv > LEVEL_MAX) step = 8'(LEVEL_MAX) - 8'd1;
    else step = 8'(lv) - 8'd1;
    return CMD_DIM_BASE | step;
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic first, input logic last);
    out_item_t o;
    o.tx_byte = b;
    o.first_of_transfer = first;
    o.last_of_transfer = last;
    bus_bytes_due.push_back(o);
  endfunction

  function automatic void push_cmd(input logic [7:0] cmd);
    push_byte(dev_addr, 1'b1, 1'b0);
    push_byte(cmd, 1'b0, 1'b1);
  endfunction

  function automatic void predict_bus_bytes(input in_item_t it);
    int unsigned idx;
    case (req_e'(it.req_type))
      REQ_DRAW: begin
        if (it.col < COLUMNS) begin
          idx = 2 * it.col + it.row[3];
          frame_img[idx][it.row[2:0]] = it.value;
        end
      end
      REQ_FILL: begin
        foreach (frame_img[i]) frame_img[i] = {8{it.value}};
      end
      REQ_REFRESH: begin
        push_byte(dev_addr, 1'b1, 1'b0);
        push_byte(ram_ptr, 1'b0, 1'b0);
        foreach (frame_img[i]) push_byte(frame_img[i], 1'b0, 1'b0);
        for (int i = 0; i < PAD_BYTES; i++) push_byte(8'h00, 1'b0, i == PAD_BYTES - 1);
      end
      REQ_DISPLAY: push_cmd(it.value ? (CMD_DISPLAY_ON | {5'd0, it.blink, 1'b0}) : CMD_DISPLAY_OFF);
      REQ_BRIGHT: push_cmd(brightness_code(it.level));
      REQ_BREATH: begin
        if (breath_up) begin
          if (breath_lvl <= BREATH_TOP) begin
            push_cmd(brightness_code(breath_lvl));
            breath_lvl = breath_lvl + 5'd1;
          end else begin
            breath_lvl = BREATH_TOP;
            breath_up = 1'b0;
          end
        end else if (breath_lvl != 5'd0) begin
          push_cmd(brightness_code(breath_lvl));
          breath_lvl = breath_lvl - 5'd1;
        end else begin
          breath_lvl = 5'd1;
          breath_up = 1'b1;
        end
      end
      REQ_SLEEP: push_cmd(CMD_SLEEP);
      default: push_cmd(CMD_WAKE);
    endcase
  endfunction

  function automatic in_item_t mk(input req_e kind, input logic [2:0] c, input logic [3:0] r,
                                  input logic v, input logic [1:0] b, input logic [4:0] lv);
    in_item_t it;
    it.req_type = kind;
    it.col = c;
    it.row = r;
    it.value = v;
    it.blink = b;
    it.level = lv;
    return it;
  endfunction

  function automatic in_item_t any_item(input req_e kind);
    logic [31:0] r;
    in_item_t it;
    r = $urandom;
    it = r[$bits(in_item_t)-1:0];
    it.req_type = kind;
    if (kind == REQ_DRAW && $urandom_range(0, 9) != 0) it.col = 3'($urandom_range(0, COLUMNS - 1));
    return it;
  endfunction

  function automatic void add_item(input in_item_t it);
    pending_reqs.push_back(it);
    if (!(req_e'(it.req_type) == REQ_DRAW && it.col >= COLUMNS)) queued_items++;
  endfunction

  task automatic queue_random_traffic(input int unsigned count);
    int unsigned goal;
    int unsigned scen;
    goal = queued_items + count;
    while (queued_items < goal) begin
      scen = $urandom_range(0, 19);
      if (scen < 8) begin
        repeat ($urandom_range(1, 8)) add_item(any_item(REQ_DRAW));
        add_item(any_item(REQ_REFRESH));
      end else if (scen < 11) begin
        repeat ($urandom_range(3, 20)) add_item(any_item(REQ_BREATH));
      end else if (scen == 11) begin
        add_item(any_item(REQ_FILL));
        add_item(any_item(REQ_REFRESH));
      end else begin
        add_item(any_item(req_e'($urandom_range(0, 7))));
      end
    end
  endtask

  task automatic wait_for_drain();
    while (pending_reqs.size() != 0 || in_valid_i || bus_bytes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [7:0] addr, input logic [7:0] ptr);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_DEV_ADDR;
    cfg_data_i <= addr;
    @(posedge clk_i);
    cfg_idx_i <= CFG_RAM_PTR;
    cfg_data_i <= ptr;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dev_addr = addr;
    ram_ptr = ptr;
    reg_settings++;
  endtask

  // Sender: bursts of random length separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_bus_bytes(in_data_i);
        items_taken[in_data_i.req_type]++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_reqs.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern switches between open, random and one-in-three
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        bytes_checked++;
        if (bus_bytes_due.size() == 0) begin
          flag_error($sformatf("unexpected transfer, byte %02h", out_data_o.tx_byte));
        end else begin
          if (out_data_o.tx_byte !== bus_bytes_due[0].tx_byte)
            flag_error($sformatf("tx_byte %02h, expected %02h",
                                 out_data_o.tx_byte, bus_bytes_due[0].tx_byte));
          if (out_data_o.first_of_transfer !== bus_bytes_due[0].first_of_transfer)
            flag_error($sformatf("first_of_transfer %b, expected %b",
                                 out_data_o.first_of_transfer, bus_bytes_due[0].first_of_transfer));
          if (out_data_o.last_of_transfer !== bus_bytes_due[0].last_of_transfer)
            flag_error($sformatf("last_of_transfer %b, expected %b",
                                 out_data_o.last_of_transfer, bus_bytes_due[0].last_of_transfer));
          void'(bus_bytes_due.pop_front());
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      stall_phase++;
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= (stall_phase % 3 == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: cleared frame, dot corners, ignored columns, fills, every command
    add_item(mk(REQ_REFRESH, 3'd0, 4'd0, 1'b0, 2'd0, 5'd0));
    add_item(mk(REQ_DRAW, 3'd0, 4'd0, 1'b1, 2'd0, 5'd0));
    add_item(mk(REQ_DRAW, 3'd5, 4'd15, 1'b1, 2'd3, 5'd31));
    add_item(mk(REQ_DRAW, 3'd7, 4'd3, 1'b1, 2'd0, 5'd0));
    add_item(mk(REQ_DRAW, 3'd6, 4'd8, 1'b1, 2'd0, 5'd0));
    add_item(mk(REQ_DRAW, 3'd5, 4'd15, 1'b0, 2'd0, 5'd0));
    add_item(mk(REQ_REFRESH, 3'd7, 4'd15, 1'b1, 2'd3, 5'd31));
    add_item(mk(REQ_FILL, 3'd0, 4'd0, 1'b1, 2'd0, 5'd0));
    add_item(mk(REQ_REFRESH, 3'd0, 4'd0, 1'b0, 2'd0, 5'd0));
    add_item(mk(REQ_FILL, 3'd0, 4'd0, 1'b0, 2'd0, 5'd0));
    add_item(mk(REQ_DRAW, 3'd3, 4'd7, 1'b1, 2'd0, 5'd0));
    add_item(mk(REQ_REFRESH, 3'd0, 4'd0, 1'b0, 2'd0, 5'd0));
    for (int b = 0; b < 4; b++) add_item(mk(REQ_DISPLAY, 3'd0, 4'd0, 1'b1, 2'(b), 5'd0));
    add_item(mk(REQ_DISPLAY, 3'd0, 4'd0, 1'b0, 2'd3, 5'd0));
    add_item(mk(REQ_BRIGHT, 3'd0, 4'd0, 1'b0, 2'd0, 5'd0));
    add_item(mk(REQ_BRIGHT, 3'd0, 4'd0, 1'b0, 2'd0, 5'd1));
    add_item(mk(REQ_BRIGHT, 3'd0, 4'd0, 1'b0, 2'd0, 5'd15));
    add_item(mk(REQ_BRIGHT, 3'd0, 4'd0, 1'b0, 2'd0, 5'd16));
    add_item(mk(REQ_BRIGHT, 3'd0, 4'd0, 1'b0, 2'd0, 5'd31));
    add_item(mk(REQ_BREATH, 3'd0, 4'd0, 1'b0, 2'd0, 5'd0));
    add_item(mk(REQ_SLEEP, 3'd0, 4'd0, 1'b0, 2'd0, 5'd0));
    add_item(mk(REQ_WAKE, 3'd0, 4'd0, 1'b0, 2'd0, 5'd0));
    queue_random_traffic(60);
    wait_for_drain();

    program_regs(8'h00, 8'hFF);
    queue_random_traffic(70);
    wait_for_drain();

    program_regs(8'hFF, 8'h00);
    queue_random_traffic(70);
    wait_for_drain();

    program_regs(8'($urandom), 8'($urandom));
    queue_random_traffic(70);
    wait_for_drain();

    program_regs(DEV_ADDR_RESET, 8'($urandom));
    queue_random_traffic(60);
    wait_for_drain();

    $display("Ran %0d requests (%0d dot draws, %0d refreshes, %0d breath ticks) over %0d register settings",
             items_taken[REQ_DRAW] + items_taken[REQ_FILL] + items_taken[REQ_REFRESH] +
             items_taken[REQ_DISPLAY] + items_taken[REQ_BRIGHT] + items_taken[REQ_BREATH] +
             items_taken[REQ_SLEEP] + items_taken[REQ_WAKE],
             items_taken[REQ_DRAW], items_taken[REQ_REFRESH], items_taken[REQ_BREATH], reg_settings);
    $display("Compared %0d bus bytes, %0d mismatches", bytes_checked, err_count);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
